@@ sv/oal_pkg.sv @@
// Shared types and constants for the ordered array list unit.
package oal_pkg;

   localparam int FIELD_KEY_W = 32;
   localparam int FIELD_POS_W = 7;
   localparam int FIELD_IDX_W = 6;
   localparam int FIELD_CNT_W = 7;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_SEARCH = 2'd3
   } oal_op_type;

   typedef struct packed {
      oal_op_type                     op;
      logic signed [FIELD_KEY_W-1:0]  key;
      logic [FIELD_POS_W-1:0]         position;
   } oal_req_type;

   typedef struct packed {
      logic                   ok;
      logic [FIELD_IDX_W-1:0] found_index;
      logic [FIELD_CNT_W-1:0] count;
   } oal_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_EXECUTE
   } oal_state_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic execute;
   } oal_cmd_type;

endpackage

@@ sv/oal_ctrl.sv @@
// Controller state machine: sequences capture, compare and execute steps.
module oal_ctrl import oal_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output oal_cmd_type cmd
);

   oal_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = ST_EXECUTE;
         end
         ST_EXECUTE: begin
            // next item may enter while this one retires
            state_in = start ? ST_COMPARE : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b0;
      cmd.capture = 1'b0;
      cmd.compare = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_COMPARE: begin
            busy        = 1'b1;
            cmd.compare = 1'b1;
         end
         ST_EXECUTE: begin
            cmd.execute = 1'b1;
            cmd.capture = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/oal_dpath.sv @@
// Datapath: row of key cells with parallel compare and shift, count and result registers.
module oal_dpath import oal_pkg::*; #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  oal_cmd_type cmd,
   input  oal_req_type req_data,
   output logic        rsp_valid,
   output oal_rsp_type rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > FIELD_POS_W) ? CNT_W : FIELD_POS_W;

   oal_req_type           req_ff;
   logic [KEY_WIDTH-1:0]  cell_ff [DEPTH];
   logic [KEY_WIDTH-1:0]  cell_in [DEPTH];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DEPTH-1:0]      match_ff, match_in;
   logic                  rsp_valid_ff;
   oal_rsp_type           rsp_ff, rsp_in;

   logic [KEY_WIDTH+FIELD_KEY_W-1:0] key_ext;
   logic [KEY_WIDTH-1:0]  key_w;
   logic [DEPTH-1:0]      low_mask, hot, below;
   logic                  hit;
   logic [IDX_W-1:0]      hit_idx;
   logic [CMP_W-1:0]      pos_w, cnt_w;
   logic                  ins_ok;
   logic                  op_ok;
   logic [FIELD_IDX_W-1:0] idx_out;

   // only the low KEY_WIDTH bits of the key are stored and compared
   assign key_ext = {{KEY_WIDTH{1'b0}}, req_ff.key};
   assign key_w   = key_ext[KEY_WIDTH-1:0];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (cell_ff[i] == key_w) && (CNT_W'(i) < count_ff);
      end
   end

   // first match: m ^ (m-1) marks bits up to and including the lowest set bit
   assign low_mask = match_ff ^ (match_ff - {{(DEPTH-1){1'b0}}, 1'b1});
   assign hot      = low_mask & match_ff;
   assign below    = low_mask ^ hot;
   assign hit      = |match_ff;

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (hot[i]) hit_idx = hit_idx | IDX_W'(i);
      end
   end

   assign pos_w  = CMP_W'(req_ff.position);
   assign cnt_w  = CMP_W'(count_ff);
   assign ins_ok = (count_ff < CNT_W'(DEPTH)) && (pos_w <= cnt_w);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
      end
      count_in = count_ff;
      op_ok    = 1'b0;
      idx_out  = '0;
      if (cmd.execute) begin
         case (req_ff.op)
            OP_CLEAR: begin
               count_in = '0;
               op_ok    = 1'b1;
            end
            OP_INSERT: begin
               if (ins_ok) begin
                  if (pos_w == CMP_W'(0)) cell_in[0] = key_w;
                  for (int i = 1; i < DEPTH; i++) begin
                     if (CMP_W'(i) == pos_w) begin
                        cell_in[i] = key_w;
                     end else if (CMP_W'(i) > pos_w) begin
                        cell_in[i] = cell_ff[i-1];
                     end
                  end
                  count_in = count_ff + CNT_W'(1);
                  op_ok    = 1'b1;
                  idx_out  = FIELD_IDX_W'(req_ff.position);
               end
            end
            OP_REMOVE: begin
               if (hit) begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     if (!below[i]) cell_in[i] = cell_ff[i+1];
                  end
                  count_in = count_ff - CNT_W'(1);
                  op_ok    = 1'b1;
                  idx_out  = FIELD_IDX_W'(hit_idx);
               end
            end
            OP_SEARCH: begin
               if (hit) begin
                  op_ok   = 1'b1;
                  idx_out = FIELD_IDX_W'(hit_idx);
               end
            end
            default: begin
               op_ok = 1'b0;
            end
         endcase
      end
      rsp_in.ok          = op_ok;
      rsp_in.found_index = idx_out;
      rsp_in.count       = FIELD_CNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.execute;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.compare) match_ff <= match_in;
      if (cmd.execute) rsp_ff <= rsp_in;
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/ordered_array_list_unit.sv @@
// Top level of the ordered array list unit: controller plus datapath.
//
//  channel   ports                     handshake
//  request   start, busy, req_data     taken at a clock edge with start high, busy low
//  result    rsp_valid, rsp_data       one cycle strobe, no back-pressure
//
// An item passes a compare step that checks every cell against the key in parallel, then
// an execute step that picks the first match, shifts the cell row and updates the count.
// busy is high only in the compare step; a new item can enter during the execute step.
// The result appears in the cycle after the execute step, for exactly one cycle.
// Synchronous reset empties the list; cell contents are left as they are.
module ordered_array_list_unit import oal_pkg::*; #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  oal_req_type req_data,
   output logic        rsp_valid,
   output oal_rsp_type rsp_data
);

   oal_cmd_type cmd;

   oal_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   oal_dpath #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_accept_to_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not enter compare");

   a_rsp_after_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy, 2))
      else $error("result without a compare step");

   a_fail_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.found_index == '0))
      else $error("failed item reports nonzero index");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.count) <= DEPTH || DEPTH > 127))
      else $error("count above depth");

endmodule
